// ===== rtl/core/scancode_char_fifo_core_defines.svh =====
// Assertion macros for the checker file of the scancode character FIFO.
`ifndef SCANCODE_CHAR_FIFO_CORE_DEFINES_SVH
`define SCANCODE_CHAR_FIFO_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scancode char fifo check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scancode char fifo check failed");

`endif

// ===== rtl/core/scf_pkg.sv =====
package scf_pkg;

	localparam int FUNC_W = 2;
	localparam int CHAR_W = 8;
	localparam int FILL_W = 11;

	localparam logic [FUNC_W-1:0] FUNC_SCAN  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	localparam logic [6:0] KEY_DIGIT_LO  = 7'h02;
	localparam logic [6:0] KEY_DIGIT_HI  = 7'h0b;
	localparam logic [6:0] KEY_TOP_LO    = 7'h10;
	localparam logic [6:0] KEY_TOP_HI    = 7'h19;
	localparam logic [6:0] KEY_HOME_LO   = 7'h1e;
	localparam logic [6:0] KEY_HOME_HI   = 7'h26;
	localparam logic [6:0] KEY_BOTTOM_LO = 7'h2c;
	localparam logic [6:0] KEY_BOTTOM_HI = 7'h32;
	localparam logic [6:0] KEY_SPACE     = 7'h39;
	localparam logic [6:0] KEY_ENTER     = 7'h1c;

	localparam logic [CHAR_W-1:0] CH_QMARK   = 8'h3f;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;

	localparam logic [CHAR_W-1:0] DIGIT_ROW [10] =
		'{"1", "2", "3", "4", "5", "6", "7", "8", "9", "0"};
	localparam logic [CHAR_W-1:0] TOP_ROW [10] =
		'{"q", "w", "e", "r", "t", "y", "u", "i", "o", "p"};
	localparam logic [CHAR_W-1:0] HOME_ROW [9] =
		'{"a", "s", "d", "f", "g", "h", "j", "k", "l"};
	localparam logic [CHAR_W-1:0] BOTTOM_ROW [7] =
		'{"z", "x", "c", "v", "b", "n", "m"};

	typedef struct packed {
		logic push_try;
		logic pop_try;
		logic clear;
	} scf_req_t;

	typedef struct packed {
		logic full;
		logic pushed;
		logic popped;
	} scf_sts_t;

	function automatic logic [CHAR_W-1:0] decode_key(input logic [6:0] code);
		logic [6:0]        off;
		logic [CHAR_W-1:0] ch;
		ch  = CH_QMARK;
		off = '0;
		if (code >= KEY_DIGIT_LO && code <= KEY_DIGIT_HI) begin
			off = code - KEY_DIGIT_LO;
			ch  = DIGIT_ROW[off[3:0]];
		end else if (code >= KEY_TOP_LO && code <= KEY_TOP_HI) begin
			off = code - KEY_TOP_LO;
			ch  = TOP_ROW[off[3:0]];
		end else if (code >= KEY_HOME_LO && code <= KEY_HOME_HI) begin
			off = code - KEY_HOME_LO;
			ch  = HOME_ROW[off[3:0]];
		end else if (code >= KEY_BOTTOM_LO && code <= KEY_BOTTOM_HI) begin
			off = code - KEY_BOTTOM_LO;
			ch  = BOTTOM_ROW[off[2:0]];
		end else if (code == KEY_SPACE) begin
			ch = CH_SPACE;
		end else if (code == KEY_ENTER) begin
			ch = CH_NEWLINE;
		end
		return ch;
	endfunction

endpackage

// ===== rtl/core/scf_ram.sv =====
module scf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/scf_ptr.sv =====
module scf_ptr
	import scf_pkg::*;
#(
	parameter int FIFO_DEPTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  scf_req_t                        req,
	output scf_sts_t                        sts,
	output logic [$clog2(FIFO_DEPTH)-1:0]   wr_addr,
	output logic [$clog2(FIFO_DEPTH)-1:0]   rd_addr,
	output logic [$clog2(FIFO_DEPTH+1)-1:0] count_nxt
);

	localparam int AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [AW-1:0]    LAST_POS = AW'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CNT_W-1:0] count_q;
	logic [AW-1:0]    wr_nxt;
	logic [AW-1:0]    rd_nxt;
	logic             full;
	logic             empty;
	logic             push;
	logic             pop;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign push  = req.push_try && !full;
	assign pop   = req.pop_try && !empty;

	always_comb begin
		wr_nxt    = wr_q;
		rd_nxt    = rd_q;
		count_nxt = count_q;
		if (req.clear) begin
			wr_nxt    = '0;
			rd_nxt    = '0;
			count_nxt = '0;
		end else if (push) begin
			wr_nxt    = (wr_q == LAST_POS) ? '0 : wr_q + AW'(1);
			count_nxt = count_q + CNT_W'(1);
		end else if (pop) begin
			rd_nxt    = (rd_q == LAST_POS) ? '0 : rd_q + AW'(1);
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_nxt;
			rd_q    <= rd_nxt;
			count_q <= count_nxt;
		end
	end

	assign wr_addr    = wr_q;
	assign rd_addr    = rd_q;
	assign sts.full   = full;
	assign sts.pushed = push;
	assign sts.popped = pop;

endmodule

// ===== rtl/core/scancode_char_fifo_core.sv =====
// Decodes set-1 keyboard scancodes to ASCII and queues pressed characters in a
// circular FIFO of FIFO_DEPTH entries held in one synchronous RAM; read and
// clear transfers pop a character or empty the queue. Every input transfer
// gives exactly one result transfer. A new input transfer is taken every
// cycle as long as results are taken; each input passes through the stage-1
// registers and the RAM read register, and then through the result register.
module scancode_char_fifo_core
	import scf_pkg::*;
#(
	parameter int FIFO_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              scan_valid,
	output logic              scan_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [7:0]        scan_code,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [CHAR_W-1:0] decoded_char,
	output logic              stored,
	output logic              dropped,
	output logic [CHAR_W-1:0] read_char,
	output logic              read_valid,
	output logic [FILL_W-1:0] fill_level
);

	localparam int AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic                    in_fire;
	logic                    advance;
	logic [CHAR_W-1:0]       ch;
	logic                    is_scan;
	logic                    storable;
	scf_req_t                req;
	scf_sts_t                sts;
	logic [AW-1:0]           wr_addr;
	logic [AW-1:0]           rd_addr;
	logic [CNT_W-1:0]        count_nxt;
	logic [CNT_W+FILL_W-1:0] count_ext;
	logic [CHAR_W-1:0]       rdata;

	logic                    valid_s1;
	logic [CHAR_W-1:0]       dec_s1;
	logic                    stored_s1;
	logic                    dropped_s1;
	logic                    rv_s1;
	logic [FILL_W-1:0]       fill_s1;

	logic                    res_valid_q;
	logic [CHAR_W-1:0]       dec_q;
	logic                    stored_q;
	logic                    dropped_q;
	logic [CHAR_W-1:0]       read_char_q;
	logic                    rv_q;
	logic [FILL_W-1:0]       fill_q;

	assign advance    = valid_s1 && (!res_valid_q || !res_stall);
	assign scan_stall = valid_s1 && !advance;
	assign in_fire    = scan_valid && !scan_stall;

	assign ch       = decode_key(scan_code[6:0]);
	assign is_scan  = (func == FUNC_SCAN);
	assign storable = is_scan && !scan_code[7] && (ch != CH_QMARK);

	assign req.push_try = in_fire && storable;
	assign req.pop_try  = in_fire && (func == FUNC_READ);
	assign req.clear    = in_fire && (func == FUNC_CLEAR);

	scf_ptr #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_ptr (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.sts      (sts),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.count_nxt(count_nxt)
	);

	scf_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(FIFO_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (sts.pushed),
		.waddr(wr_addr),
		.wdata(ch),
		.re   (sts.popped),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign count_ext = {{FILL_W{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			dec_s1     <= is_scan ? ch : '0;
			stored_s1  <= sts.pushed;
			dropped_s1 <= req.push_try && sts.full;
			rv_s1      <= sts.popped;
			fill_s1    <= count_ext[FILL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dec_q       <= dec_s1;
			stored_q    <= stored_s1;
			dropped_q   <= dropped_s1;
			read_char_q <= rv_s1 ? rdata : '0;
			rv_q        <= rv_s1;
			fill_q      <= fill_s1;
		end
	end

	assign res_valid    = res_valid_q;
	assign decoded_char = dec_q;
	assign stored       = stored_q;
	assign dropped      = dropped_q;
	assign read_char    = read_char_q;
	assign read_valid   = rv_q;
	assign fill_level   = fill_q;

endmodule

// ===== rtl/core/scf_checker.sv =====
`include "scancode_char_fifo_core_defines.svh"

module scf_checker
	import scf_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_stall,
	input logic [CHAR_W-1:0] decoded_char,
	input logic              stored,
	input logic              dropped,
	input logic [CHAR_W-1:0] read_char,
	input logic              read_valid,
	input logic [FILL_W-1:0] fill_level
);

	`SCF_ASSERT_SAME(a_store_xor_drop, res_valid, !(stored && dropped))
	`SCF_ASSERT_SAME(a_read_no_decode, res_valid && read_valid, decoded_char == '0 && !stored)
	`SCF_ASSERT_SAME(a_no_char_no_read, res_valid && !read_valid, read_char == '0)
	`SCF_ASSERT_SAME(a_store_has_fill, res_valid && stored, fill_level != '0)
	`SCF_ASSERT_NEXT(a_res_held, res_valid && res_stall, res_valid)

endmodule

bind scancode_char_fifo_core scf_checker u_scf_checker (.*);
